[sv/lsm_pkg.sv]
// shared types, constants and helpers for the line substring matcher
// no dependencies; imported by every module of the block
`default_nettype none

package lsm_pkg;

    localparam int PATTERN_MAX = 16;
    // history cells; one is kept even when the maximum pattern length is one byte
    localparam int CELL_COUNT  = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
    localparam int LEN_W       = 5;
    localparam int USED_W      = $clog2(PATTERN_MAX + 1);
    localparam int LINE_W      = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int RES_DEPTH   = 4;
    localparam int RES_PTR_W   = $clog2(RES_DEPTH);
    localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd2;

    typedef struct packed {
        logic [LINE_W-1:0] line_number;
        logic              is_end_marker;
        logic              any_found;
    } result_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // pattern byte at a given index; bytes outside the two words read as zero
    function automatic logic [7:0] pattern_byte(
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi,
        input int                    idx
    );
        logic [2:0] k;
        logic [7:0] val;
        k   = idx[2:0];
        val = 8'd0;
        if (idx >= 0 && idx < 8) begin
            val = lo[{k, 3'b000} +: 8];
        end
        else if (idx >= 8 && idx < 16) begin
            val = hi[{k, 3'b000} +: 8];
        end
        return val;
    endfunction

endpackage

`default_nettype wire

[sv/lsm_cell.sv]
// one history cell: holds an earlier byte of the line and compares it
// against the pattern byte aligned to its position; uses lsm_pkg
`default_nettype none

module lsm_cell
    import lsm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire logic [7:0] byte_in,
    input  wire logic       vld_in,
    input  wire logic [7:0] expect_byte,
    input  wire logic       in_use,
    output logic [7:0]      byte_out,
    output logic            vld_out,
    output logic            ok
);

    logic [7:0] byte_reg;
    logic       vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end
        else if (ctrl.clear) begin
            vld_reg <= 1'b0;
        end
        else if (ctrl.shift) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;
    assign vld_out  = vld_reg;
    // a cell past the pattern span never blocks a match
    assign ok       = !in_use || (vld_reg && (byte_reg == expect_byte));

endmodule

`default_nettype wire

[sv/lsm_result_fifo.sv]
// small result queue between the matcher and the output channel;
// takes up to two results per cycle, hands out one; uses lsm_pkg
`default_nettype none

module lsm_result_fifo
    import lsm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [1:0] push_cnt,
    input  wire result_t    push_first,
    input  wire result_t    push_second,
    input  wire logic       pop,
    output result_t         head,
    output logic            not_empty,
    output logic            has_room
);

    result_t                mem [RES_DEPTH];
    logic [RES_PTR_W-1:0]   wr_ptr_reg;
    logic [RES_PTR_W-1:0]   wr_ptr_next;
    logic [RES_PTR_W-1:0]   rd_ptr_reg;
    logic [RES_PTR_W-1:0]   rd_ptr_next;
    logic [RES_CNT_W-1:0]   count_reg;
    logic [RES_CNT_W-1:0]   count_next;
    logic [RES_PTR_W-1:0]   wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + RES_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push_cnt);
        rd_ptr_next = pop ? rd_ptr_reg + RES_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + RES_CNT_W'(push_cnt) - RES_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push_first;
        end
        if (push_cnt == 2'd2) begin
            mem[wr_ptr_plus1] <= push_second;
        end
    end

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    // an item may add two results, so keep two slots free
    assign has_room  = (count_reg <= RES_CNT_W'(RES_DEPTH - 2));

endmodule

`default_nettype wire

[sv/line_substring_matcher_core.sv]
// line substring matcher: reports the number of every text line holding
// the configured pattern; uses lsm_pkg, lsm_cell and lsm_result_fifo
//
// usage:
//   text enters one byte per item on in_valid/in_ready (text_byte, and
//   end_of_text which closes the stream). a newline byte closes a line;
//   a matching line yields one item on out_valid/out_ready carrying its
//   1-based line_number. end_of_text closes an open last line and then
//   yields an end marker (is_end_marker=1, any_found) and restarts the
//   line count at one.
//   the pattern is set on cfg_valid/cfg_ready (always ready): index 0 is
//   the length, 1 and 2 the low and high pattern words; write only while
//   idle.
//   throughput is one byte per cycle while the result queue has room: a row
//   of history cells shifts the last bytes of the line and all of them
//   compare in parallel. results enter the result queue as the item that
//   closes the line is accepted. an end item may add two results; in_ready
//   drops while the 4-entry result queue has fewer than two free slots, so
//   a stalled receiver holds back input after a few results. reset clears
//   the line state, queue and pattern registers.
`default_nettype none

module line_substring_matcher_core
    import lsm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            text_byte,
    input  wire logic                  end_of_text,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [LINE_W-1:0]          line_number,
    output logic                       is_end_marker,
    output logic                       any_found
);

    logic [LEN_W-1:0]      pattern_length_reg;
    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;

    logic                  line_matched_reg;
    logic                  line_matched_next;
    logic                  line_open_reg;
    logic                  line_open_next;
    logic [LINE_W-1:0]     current_line_reg;
    logic [LINE_W-1:0]     current_line_next;
    logic                  found_flag_reg;
    logic                  found_flag_next;

    logic [USED_W-1:0]     len_used;
    logic                  in_fire;
    logic                  is_newline;
    logic                  is_text;
    logic                  close_line;
    logic                  line_hit;
    logic                  last_ok;
    logic                  byte_match;
    cell_ctrl_t            cell_ctrl;

    logic [7:0]            cell_byte [CELL_COUNT];
    logic                  cell_vld  [CELL_COUNT];
    logic [CELL_COUNT-1:0] cell_ok;

    result_t               line_res;
    result_t               end_res;
    result_t               push_first;
    logic [1:0]            push_cnt;
    result_t               head;
    logic                  fifo_not_empty;
    logic                  fifo_has_room;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pattern_length_reg <= '0;
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                REG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign len_used = (int'(pattern_length_reg) > PATTERN_MAX) ?
                      USED_W'(PATTERN_MAX) : USED_W'(pattern_length_reg);

    assign in_fire    = in_valid && in_ready;
    assign is_newline = !end_of_text && (text_byte == NEWLINE_BYTE);
    assign is_text    = !end_of_text && !is_newline;

    assign cell_ctrl.shift = in_fire && is_text;
    assign cell_ctrl.clear = in_fire && !is_text;

    // history row: cell 0 holds the previous byte, later cells older ones
    for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
        logic [7:0] nb_byte;
        logic       nb_vld;
        logic       use_here;
        logic [7:0] exp_byte;

        if (i == 0) begin : g_first
            assign nb_byte = text_byte;
            assign nb_vld  = 1'b1;
        end
        else begin : g_rest
            assign nb_byte = cell_byte[i-1];
            assign nb_vld  = cell_vld[i-1];
        end

        assign use_here = (int'(len_used) >= i + 2);
        assign exp_byte = pattern_byte(pattern_low_reg, pattern_high_reg,
                                       int'(len_used) - 2 - i);

        lsm_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .byte_in     (nb_byte),
            .vld_in      (nb_vld),
            .expect_byte (exp_byte),
            .in_use      (use_here),
            .byte_out    (cell_byte[i]),
            .vld_out     (cell_vld[i]),
            .ok          (cell_ok[i])
        );
    end

    assign last_ok    = (pattern_byte(pattern_low_reg, pattern_high_reg,
                                      int'(len_used) - 1) == text_byte);
    assign byte_match = (len_used != '0) && last_ok && (&cell_ok);

    assign close_line = is_newline || (end_of_text && line_open_reg);
    assign line_hit   = close_line && (line_matched_reg || (len_used == '0));

    always_comb
    begin
        line_matched_next = line_matched_reg;
        line_open_next    = line_open_reg;
        current_line_next = current_line_reg;
        found_flag_next   = found_flag_reg;
        if (in_fire) begin
            if (end_of_text) begin
                line_matched_next = 1'b0;
                line_open_next    = 1'b0;
                current_line_next = LINE_W'(1);
                found_flag_next   = 1'b0;
            end
            else if (is_newline) begin
                line_matched_next = 1'b0;
                line_open_next    = 1'b0;
                if (current_line_reg != '1) begin
                    current_line_next = current_line_reg + LINE_W'(1);
                end
                found_flag_next = found_flag_reg || line_hit;
            end
            else begin
                line_open_next    = 1'b1;
                line_matched_next = line_matched_reg || byte_match;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            line_matched_reg <= 1'b0;
            line_open_reg    <= 1'b0;
            current_line_reg <= LINE_W'(1);
            found_flag_reg   <= 1'b0;
        end
        else begin
            line_matched_reg <= line_matched_next;
            line_open_reg    <= line_open_next;
            current_line_reg <= current_line_next;
            found_flag_reg   <= found_flag_next;
        end
    end

    // results of the accepted item, line result ahead of the end marker
    always_comb
    begin
        line_res.line_number   = current_line_reg;
        line_res.is_end_marker = 1'b0;
        line_res.any_found     = 1'b0;
        end_res.line_number    = '0;
        end_res.is_end_marker  = 1'b1;
        end_res.any_found      = found_flag_reg || line_hit;
        push_first             = line_hit ? line_res : end_res;
        push_cnt               = in_fire ?
                                 (2'(line_hit) + 2'(end_of_text)) : 2'd0;
    end

    lsm_result_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_cnt    (push_cnt),
        .push_first  (push_first),
        .push_second (end_res),
        .pop         (out_valid && out_ready),
        .head        (head),
        .not_empty   (fifo_not_empty),
        .has_room    (fifo_has_room)
    );

    assign in_ready      = fifo_has_room;
    assign out_valid     = fifo_not_empty;
    assign line_number   = head.line_number;
    assign is_end_marker = head.is_end_marker;
    assign any_found     = head.any_found;

`ifndef SYNTHESIS
    // the first history cell holds a byte exactly while a line is open
    a_open_tracks_cell: assert property (@(posedge clk) disable iff (!rst_n)
        cell_vld[0] == line_open_reg)
        else $error("line open flag and history row disagree");

    // an end item restarts the stream state
    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && end_of_text) |=>
            (current_line_reg == LINE_W'(1)) && !found_flag_reg && !line_open_reg)
        else $error("stream state not restarted after end item");

    // the found flag clears only through an end item
    a_found_clears: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(found_flag_reg) |-> $past(in_fire && end_of_text))
        else $error("found flag cleared without an end item");
`endif

endmodule

`default_nettype wire

[tb/lsm_result_checker.sv]
`timescale 1ns / 1ps
// lsm_result_checker: watches the config, text and result channels of the
// line substring matcher, predicts every result and compares it; uses lsm_pkg

module lsm_result_checker
    import lsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [7:0]            text_byte,
    input  logic                  end_of_text,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [LINE_W-1:0]     line_number,
    input  logic                  is_end_marker,
    input  logic                  any_found,
    output int                    fail_count,
    output int                    pending,
    output int                    results_seen
);

    localparam logic [4:0]        FILL_TOP = 5'd31;
    localparam logic [LINE_W-1:0] LINE_TOP = '1;

    // pattern registers
    logic [4:0]            pat_len_reg;
    logic [CFG_DATA_W-1:0] pat_lo;
    logic [CFG_DATA_W-1:0] pat_hi;

    // stream state
    logic [7:0]        history [CELL_COUNT];
    logic [4:0]        line_fill;
    bit                line_hit;
    bit                line_busy;
    bit                any_hit;
    logic [LINE_W-1:0] line_count;

    result_t due_q[$];
    int      errors;
    int      seen;

    function automatic int active_len();
        return (pat_len_reg > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len_reg);
    endfunction

    function automatic logic [7:0] pat_at(input int i);
        if (i < 8)
            return pat_lo[i*8 +: 8];
        else if (i < 16)
            return pat_hi[(i-8)*8 +: 8];
        return 8'h00;
    endfunction

    function automatic void restart_stream();
        int k;
        for (k = 0; k < CELL_COUNT; k++)
            history[k] = 8'h00;
        line_fill  = '0;
        line_hit   = 1'b0;
        line_busy  = 1'b0;
        line_count = 1;
        any_hit    = 1'b0;
    endfunction

    function automatic void end_line();
        result_t r;
        if (line_hit || active_len() == 0)
        begin
            r.line_number   = line_count;
            r.is_end_marker = 1'b0;
            r.any_found     = 1'b0;
            due_q = {due_q, r};
            any_hit = 1'b1;
        end
        if (line_count != LINE_TOP)
            line_count = line_count + 1;
        line_fill = '0;
        line_hit  = 1'b0;
        line_busy = 1'b0;
    endfunction

    function automatic void take_item(input logic [7:0] b, input logic eot);
        result_t r;
        int      n;
        int      j;
        int      k;
        bit      hit;
        if (eot)
        begin
            if (line_busy)
                end_line();
            r.line_number   = '0;
            r.is_end_marker = 1'b1;
            r.any_found     = any_hit;
            due_q = {due_q, r};
            restart_stream();
        end
        else if (b == NEWLINE_BYTE)
        begin
            end_line();
        end
        else
        begin
            line_busy = 1'b1;
            if (line_fill < FILL_TOP)
                line_fill = line_fill + 1;
            n = active_len();
            // new byte closes the pattern, older bytes sit in the history row
            if (n > 0 && int'(line_fill) >= n && pat_at(n - 1) == b)
            begin
                hit = 1'b1;
                for (j = 1; j < n; j++)
                    if (history[j-1] != pat_at(n - 1 - j))
                        hit = 1'b0;
                if (hit)
                    line_hit = 1'b1;
            end
            for (k = CELL_COUNT - 1; k > 0; k--)
                history[k] = history[k-1];
            history[0] = b;
        end
    endfunction

    function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_PATTERN_LENGTH: pat_len_reg = data[4:0];
            REG_PATTERN_LOW:    pat_lo = data;
            REG_PATTERN_HIGH:   pat_hi = data;
            default: ;
        endcase
    endfunction

    function automatic void check_result();
        result_t want;
        seen++;
        if (due_q.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result line_number %0d end %0b found %0b",
                     $time, line_number, is_end_marker, any_found);
            return;
        end
        want = due_q.pop_front();
        if (line_number !== want.line_number)
        begin
            errors++;
            $display("%0t: line_number expected %0d got %0d",
                     $time, want.line_number, line_number);
        end
        if (is_end_marker !== want.is_end_marker)
        begin
            errors++;
            $display("%0t: is_end_marker expected %0b got %0b",
                     $time, want.is_end_marker, is_end_marker);
        end
        if (any_found !== want.any_found)
        begin
            errors++;
            $display("%0t: any_found expected %0b got %0b",
                     $time, want.any_found, any_found);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg = '0;
            pat_lo      = '0;
            pat_hi      = '0;
            restart_stream();
            due_q.delete();
            errors = 0;
            seen   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                take_item(text_byte, end_of_text);
            if (cfg_valid && cfg_ready)
                store_reg(cfg_index, cfg_data);
        end
        fail_count   <= errors;
        pending      <= due_q.size();
        results_seen <= seen;
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: text and pattern stimulus plus verdict for line_substring_matcher_core
// needs lsm_pkg, the core RTL and tb/lsm_result_checker.sv

module tb_top;
    import lsm_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TEXT_ITEMS    = 1100;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [7:0]            text_byte   = 8'h00;
    logic                  end_of_text = 1'b0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [LINE_W-1:0]     line_number;
    logic                  is_end_marker;
    logic                  any_found;

    int fail_count;
    int pending;
    int results_seen;

    bit           calm          = 1'b0;
    int           ready_hold    = 0;
    int           quiet_cycles  = 0;
    int           items_sent    = 0;
    int           texts_closed  = 0;
    int           settings_used = 0;
    int           random_start  = 0;
    int           pat_len       = 0;
    logic [127:0] pat_words     = '0;

    line_substring_matcher_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .text_byte     (text_byte),
        .end_of_text   (end_of_text),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .line_number   (line_number),
        .is_end_marker (is_end_marker),
        .any_found     (any_found)
    );

    lsm_result_checker result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .text_byte     (text_byte),
        .end_of_text   (end_of_text),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .line_number   (line_number),
        .is_end_marker (is_end_marker),
        .any_found     (any_found),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver stalls
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else if (calm || $urandom_range(0, 2) != 0)
        begin
            out_ready  <= 1'b1;
            ready_hold <= $urandom_range(0, 8);
        end
        else
        begin
            out_ready  <= 1'b0;
            ready_hold <= idle_len();
        end
    end

    // watchdog: cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_text(input logic [7:0] b, input logic eot);
        int gap;
        text_byte   <= b;
        end_of_text <= eot;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop the text and let every due result drain before touching registers
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_pattern(input logic [CFG_DATA_W-1:0] len_word,
                               input logic [CFG_DATA_W-1:0] lo,
                               input logic [CFG_DATA_W-1:0] hi,
                               input bit spare);
        settle();
        write_reg(REG_PATTERN_LENGTH, len_word);
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        if (spare)
            write_reg(REG_SPARE, {$urandom, $urandom});
        cfg_valid <= 1'b0;
        pat_words = {hi, lo};
        pat_len   = (len_word[4:0] > PATTERN_MAX) ? PATTERN_MAX : int'(len_word[4:0]);
        settings_used++;
    endtask

    task automatic random_pattern();
        logic [CFG_DATA_W-1:0] len_word;
        logic [127:0]          words;
        int                    len;
        int                    base;
        int                    tmp;
        int                    k;
        case ($urandom_range(0, 6))
            0: len = 0;
            1: len = 1;
            2: len = PATTERN_MAX;
            3: len = $urandom_range(PATTERN_MAX + 1, 31);
            default: len = $urandom_range(2, 6);
        endcase
        len_word      = {$urandom, $urandom};
        len_word[4:0] = len[4:0];
        if ($urandom_range(0, 1) == 0)
        begin
            // narrow alphabet so random filler repeats pattern bytes
            base = $urandom_range(0, 255);
            for (k = 0; k < 16; k++)
            begin
                tmp = base + $urandom_range(0, 2);
                words[k*8 +: 8] = tmp[7:0];
            end
        end
        else
        begin
            words = {$urandom, $urandom, $urandom, $urandom};
        end
        if ($urandom_range(0, 7) == 0)
            words = {64'h0, {64{1'b1}}};
        set_pattern(len_word, words[63:0], words[127:64], $urandom_range(0, 5) == 0);
    endtask

    function automatic logic [7:0] filler();
        int r;
        r = $urandom_range(0, 255);
        if (pat_len > 0 && $urandom_range(0, 1) == 0)
            return pat_words[$urandom_range(0, pat_len - 1)*8 +: 8];
        return r[7:0];
    endfunction

    task automatic send_random_line(input bit close);
        int  body;
        int  spot;
        int  i;
        int  k;
        bit  plant;
        body  = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
        plant = (pat_len > 0) && ($urandom_range(0, 1) == 0);
        spot  = $urandom_range(0, body);
        for (i = 0; i <= body; i++)
        begin
            if (plant && i == spot)
                for (k = 0; k < pat_len; k++)
                    push_text(pat_words[k*8 +: 8], 1'b0);
            if (i < body)
                push_text(filler(), 1'b0);
        end
        if (close)
            push_text(NEWLINE_BYTE, 1'b0);
    endtask

    task automatic send_text();
        int lines;
        int i;
        int ending;
        int junk;
        lines = $urandom_range(0, 5);
        for (i = 0; i < lines; i++)
            send_random_line(1'b1);
        ending = $urandom_range(0, 3);
        // unterminated last line; the last choice leaves the text open
        if (ending != 0)
            send_random_line(1'b0);
        if (ending != 3)
        begin
            junk = $urandom_range(0, 255);
            push_text(junk[7:0], 1'b1);
            texts_closed++;
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset pattern is empty: every line matches, also an empty one
        push_text("a", 1'b0);
        push_text(NEWLINE_BYTE, 1'b0);
        push_text(NEWLINE_BYTE, 1'b0);
        push_text(8'hFF, 1'b1);
        // end of an empty text yields the marker alone, nothing found
        push_text(8'h00, 1'b1);

        // plain three byte pattern, last line left open until the end item
        set_pattern(64'd3, 64'h0000_0000_0063_6261, 64'h0, 1'b0);
        push_text("x", 1'b0);
        push_text("a", 1'b0);
        push_text("b", 1'b0);
        push_text("c", 1'b0);
        push_text(NEWLINE_BYTE, 1'b0);
        push_text("z", 1'b0);
        push_text("a", 1'b0);
        push_text("b", 1'b0);
        push_text(8'h00, 1'b1);

        // byte extremes, then a pattern holding a newline written mid-line
        set_pattern(64'd2, 64'h0000_0000_0000_FF00, {64{1'b1}}, 1'b0);
        push_text(8'h00, 1'b0);
        push_text(8'hFF, 1'b0);
        set_pattern({{59{1'b1}}, 5'd2}, 64'h0000_0000_0000_710A, 64'h0, 1'b1);
        push_text("q", 1'b0);
        push_text(NEWLINE_BYTE, 1'b0);
        push_text(8'hFF, 1'b1);

        random_start = items_sent;
        while (items_sent - random_start < TEXT_ITEMS)
        begin
            random_pattern();
            calm = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 3)) send_text();
        end
        calm = 1'b0;

        settle();
        $display("tb: %0d text items in %0d closed texts over %0d pattern settings",
                 items_sent, texts_closed, settings_used);
        $display("tb: %0d results compared", results_seen);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[line_substring_matcher_core.f]
sv/lsm_pkg.sv
sv/lsm_cell.sv
sv/lsm_result_fifo.sv
sv/line_substring_matcher_core.sv
tb/lsm_result_checker.sv
tb/tb_top.sv
